[rtl/rvg_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the ring vertex generator.
// No dependencies; every other file in rtl/ imports this package.
package rvg_pkg;

    localparam int MAX_SEGMENTS     = 64;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

    // segment counter and configuration widths
    localparam int SEG_W   = 7;
    localparam int STEP_W  = 16;   // phase wraps mod 2^16, so bit 16 of the step is dropped
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 2'd1;

    localparam logic [SEG_W-1:0]  SEG_COUNT_RESET  = 7'd16;
    localparam logic [STEP_W-1:0] ANGLE_STEP_RESET = 16'd4096;

    // basis vector widths: P in [-1, 1] Q2.16, Q up to about 2^32, W clamped to +/-2^32
    localparam int PW = 18;
    localparam int QW = 35;
    localparam int WW = 34;
    localparam logic signed [PW-1:0] ONE_Q16 = 18'sd65536;

    // iterative unit step counts
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] direction_x;
        logic signed [31:0] direction_y;
        logic signed [31:0] direction_z;
        logic        [30:0] radius;
        logic        [15:0] base_index;
    } t_ring_in;

    typedef struct packed {
        logic        [15:0] point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } t_ring_out;

    // one ring, ready for point generation
    typedef struct packed {
        logic signed [31:0]   center_x;
        logic signed [31:0]   center_y;
        logic signed [31:0]   center_z;
        logic        [30:0]   radius;
        logic        [15:0]   base_index;
        logic signed [PW-1:0] p_x;
        logic signed [PW-1:0] p_z;
        logic signed [QW-1:0] q_x;
        logic signed [QW-1:0] q_y;
        logic signed [QW-1:0] q_z;
    } t_ring_job;

    typedef enum logic [3:0] {
        F_IDLE,
        F_SQUARE,
        F_SUM,
        F_SQRT,
        F_DIV_INIT,
        F_DIV,
        F_BASIS,
        F_CROSS,
        F_SHIFT,
        F_PUSH
    } t_front_state;

    typedef logic [15:0] t_sine_rom [SINE_TABLE_DEPTH];

    // round(65536*sin(pi/2*k/DEPTH)) from a Q2.30 Taylor series, clamped to 16 bits
    function automatic logic [15:0] sine_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] val;
        a    = 64'd1686629713 * 64'(k) / 64'(SINE_TABLE_DEPTH);
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        for (int n = 1; n <= 7; n++) begin
            term = (term * a2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        val = (sum + 64'd8192) >> 14;
        if (val > 64'd65535) begin
            val = 64'd65535;
        end
        return val[15:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

[rtl/rvg_front.sv]
// Front end: accepts a ring item and builds its basis (sqrt, two dividers, cross product).
// Depends on rvg_pkg; hands finished rings to rvg_fifo.
module rvg_front
    import rvg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_ring_in  i_in_item,
    input  logic      i_full,
    output logic      o_push,
    output t_ring_job o_job
);

    t_front_state r_state, n_state;

    t_ring_in           r_in;
    logic [63:0]        r_ax2, r_az2;
    logic [63:0]        r_val, r_res, r_bit;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_rem_az, r_rem_ax;
    logic [16:0]        r_dsh_az, r_dsh_ax;
    logic [16:0]        r_quo_az, r_quo_ax;
    logic signed [PW-1:0] r_px, r_pz;
    logic signed [49:0] r_ay_pz, r_az_px, r_ax_pz, r_ay_px;
    t_ring_job          r_job;

    logic [31:0] w_mag_ax, w_mag_az, w_h;
    logic [63:0] w_trial;
    logic [32:0] w_try_az, w_try_ax;
    logic signed [49:0] w_qx_full;
    logic signed [50:0] w_qy_sum, w_qz_neg;
    logic signed [50:0] w_qy_full, w_qz_full;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    assign w_mag_ax = mag32(r_in.direction_x);
    assign w_mag_az = mag32(r_in.direction_z);
    assign w_h      = r_res[31:0];
    assign w_trial  = r_res + r_bit;
    assign w_try_az = {r_rem_az, r_dsh_az[16]};
    assign w_try_ax = {r_rem_ax, r_dsh_ax[16]};

    assign w_qx_full = r_ay_pz >>> 16;
    assign w_qy_sum  = 51'(r_az_px) - 51'(r_ax_pz);
    assign w_qz_neg  = -51'(r_ay_px);
    assign w_qy_full = w_qy_sum >>> 16;
    assign w_qz_full = w_qz_neg >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_push     = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            F_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = F_SQUARE;
                end
            end
            F_SQUARE: n_state = F_SUM;
            F_SUM:    n_state = F_SQRT;
            F_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = F_DIV_INIT;
                end
            end
            F_DIV_INIT: n_state = F_DIV;
            F_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = F_BASIS;
                end
            end
            F_BASIS: n_state = F_CROSS;
            F_CROSS: n_state = F_SHIFT;
            F_SHIFT: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_item;
                end
            end
            F_SQUARE: begin
                r_ax2 <= w_mag_ax * w_mag_ax;
                r_az2 <= w_mag_az * w_mag_az;
            end
            F_SUM: begin
                r_val <= r_ax2 + r_az2;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            F_SQRT: begin
                // one result bit per step
                if (r_val >= w_trial) begin
                    r_val <= r_val - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            F_DIV_INIT: begin
                // |a|*65536/h: the top part |a|>>1 is already below h
                r_rem_az <= {1'b0, w_mag_az[31:1]};
                r_rem_ax <= {1'b0, w_mag_ax[31:1]};
                r_dsh_az <= {w_mag_az[0], 16'd0};
                r_dsh_ax <= {w_mag_ax[0], 16'd0};
                r_quo_az <= '0;
                r_quo_ax <= '0;
                r_cnt    <= '0;
            end
            F_DIV: begin
                if (w_try_az >= {1'b0, w_h}) begin
                    r_rem_az <= 32'(w_try_az - {1'b0, w_h});
                    r_quo_az <= {r_quo_az[15:0], 1'b1};
                end else begin
                    r_rem_az <= w_try_az[31:0];
                    r_quo_az <= {r_quo_az[15:0], 1'b0};
                end
                if (w_try_ax >= {1'b0, w_h}) begin
                    r_rem_ax <= 32'(w_try_ax - {1'b0, w_h});
                    r_quo_ax <= {r_quo_ax[15:0], 1'b1};
                end else begin
                    r_rem_ax <= w_try_ax[31:0];
                    r_quo_ax <= {r_quo_ax[15:0], 1'b0};
                end
                r_dsh_az <= {r_dsh_az[15:0], 1'b0};
                r_dsh_ax <= {r_dsh_ax[15:0], 1'b0};
                r_cnt    <= r_cnt + 1'b1;
            end
            F_BASIS: begin
                // vertical axis: fall back to P = (1, 0, 0)
                if (w_h == 32'd0) begin
                    r_px <= ONE_Q16;
                    r_pz <= '0;
                end else begin
                    r_px <= r_in.direction_z[31] ? -$signed({1'b0, r_quo_az})
                                                 :  $signed({1'b0, r_quo_az});
                    r_pz <= r_in.direction_x[31] ?  $signed({1'b0, r_quo_ax})
                                                 : -$signed({1'b0, r_quo_ax});
                end
            end
            F_CROSS: begin
                r_ay_pz <= r_in.direction_y * r_pz;
                r_az_px <= r_in.direction_z * r_px;
                r_ax_pz <= r_in.direction_x * r_pz;
                r_ay_px <= r_in.direction_y * r_px;
            end
            F_SHIFT: begin
                r_job.center_x   <= r_in.center_x;
                r_job.center_y   <= r_in.center_y;
                r_job.center_z   <= r_in.center_z;
                r_job.radius     <= r_in.radius;
                r_job.base_index <= r_in.base_index;
                r_job.p_x        <= r_px;
                r_job.p_z        <= r_pz;
                r_job.q_x        <= QW'(w_qx_full);
                r_job.q_y        <= w_qy_full[QW-1:0];
                r_job.q_z        <= w_qz_full[QW-1:0];
            end
            default: ;
        endcase
    end

    assign o_job = r_job;

endmodule

[rtl/rvg_fifo.sv]
// Short ring queue between the basis front end and the point generator.
// Depends on rvg_pkg for the ring type and depth.
module rvg_fifo
    import rvg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_ring_job i_data,
    input  logic      i_pop,
    output t_ring_job o_data,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    t_ring_job          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [FCNT_W-1:0]  r_count;

    assign o_full  = (r_count == FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + FCNT_W'(i_push) - FCNT_W'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("ring queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("ring queue underflow");

endmodule

[rtl/rvg_back.sv]
// Back end: steps the phase per segment; while a ring runs, one vertex per unstalled cycle in a 5-stage pipe.
// Depends on rvg_pkg (sine table, ring type); takes rings from rvg_fifo.
module rvg_back
    import rvg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SEG_W-1:0]  i_segment_count,
    input  logic [STEP_W-1:0] i_angle_step,
    input  logic              i_empty,
    input  t_ring_job         i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_ring_out         o_out_item
);

    localparam int KPROD_W = 14 + SINE_IDX_W;

    // sequencer
    t_ring_job          r_job;
    logic               r_busy;
    logic [SEG_W-1:0]   r_seg, r_count;
    logic [15:0]        r_phase;

    // stage valids, index and last flag
    logic               r1_v, r2_v, r3_v, r4_v;
    logic [15:0]        r1_idx, r2_idx, r3_idx, r4_idx;
    logic               r1_last, r2_last, r3_last, r4_last;

    logic signed [PW-1:0]   r1_sin, r1_cos;
    logic signed [35:0]     r2_cpx, r2_cpz;
    logic signed [52:0]     r2_sqx, r2_sqy, r2_sqz;
    logic signed [WW-1:0]   r3_wx, r3_wy, r3_wz;
    logic        [47:0]     r4_plx, r4_ply, r4_plz;
    logic signed [48:0]     r4_phx, r4_phy, r4_phz;

    logic               r_out_valid;
    t_ring_out          r_out_item;

    logic               w_adv, w_pipe_empty, w_load, w_last_seg;
    logic [SEG_W-1:0]   w_cnt_sat;
    logic [1:0]         w_quad;
    logic [13:0]        w_off;
    logic [KPROD_W-1:0] w_kprod;
    logic [SINE_IDX_W-1:0] w_k;
    logic [SINE_IDX_W:0]   w_kc;
    logic [16:0]        w_lo, w_hi;
    logic signed [PW-1:0] w_lo_s, w_hi_s, w_sin, w_cos;

    function automatic logic [16:0] sine_at(input logic [SINE_IDX_W:0] j);
        if (j == (SINE_IDX_W + 1)'(SINE_TABLE_DEPTH)) begin
            return 17'd65536;
        end
        return {1'b0, SINE_ROM[j[SINE_IDX_W-1:0]]};
    endfunction

    function automatic logic signed [WW-1:0] clamp_w(input logic signed [53:0] s);
        logic signed [53:0] sh;
        sh = s >>> 16;
        if (sh > 54'sd4294967296) begin
            return 34'sd4294967296;
        end else if (sh < -54'sd4294967296) begin
            return -34'sd4294967296;
        end
        return sh[WW-1:0];
    endfunction

    function automatic logic signed [31:0] coord(input logic signed [48:0] ph,
                                                 input logic [47:0] pl,
                                                 input logic signed [31:0] c);
        logic signed [66:0] prod;
        logic signed [66:0] sh;
        logic signed [51:0] sum;
        prod = (67'(ph) <<< 17) + $signed(67'(pl));
        sh   = prod >>> 16;
        sum  = 52'(sh) + 52'(c);
        if (sum > 52'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (sum < -52'sd2147483648) begin
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    assign w_adv        = !r_out_valid || !i_out_stall;
    assign w_pipe_empty = !(r1_v || r2_v || r3_v || r4_v);
    assign w_cnt_sat    = (i_segment_count > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS)
                                                                  : i_segment_count;
    // next ring only once the previous one has left the pipe
    assign w_load       = !r_busy && !i_empty && w_pipe_empty;
    assign o_pop        = w_load;
    assign w_last_seg   = (r_seg == r_count - 1'b1);

    // quarter-wave lookup
    assign w_quad  = r_phase[15:14];
    assign w_off   = r_phase[13:0];
    assign w_kprod = KPROD_W'(w_off) * KPROD_W'(SINE_TABLE_DEPTH);
    assign w_k     = w_kprod[14 +: SINE_IDX_W];
    assign w_kc    = (SINE_IDX_W + 1)'(SINE_TABLE_DEPTH) - {1'b0, w_k};
    assign w_lo    = sine_at({1'b0, w_k});
    assign w_hi    = sine_at(w_kc);
    assign w_lo_s  = $signed({1'b0, w_lo});
    assign w_hi_s  = $signed({1'b0, w_hi});

    always_comb begin
        case (w_quad)
            2'd0: begin w_sin = w_lo_s;  w_cos = w_hi_s;  end
            2'd1: begin w_sin = w_hi_s;  w_cos = -w_lo_s; end
            2'd2: begin w_sin = -w_lo_s; w_cos = -w_hi_s; end
            default: begin w_sin = -w_hi_s; w_cos = w_lo_s; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= (w_cnt_sat != '0);
            end else if (r_busy && w_adv && w_last_seg) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r1_v        <= r_busy;
                r2_v        <= r1_v;
                r3_v        <= r2_v;
                r4_v        <= r3_v;
                r_out_valid <= r4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job   <= i_job;
            r_count <= w_cnt_sat;
            r_seg   <= '0;
            r_phase <= '0;
        end else if (r_busy && w_adv) begin
            r_seg   <= r_seg + 1'b1;
            r_phase <= r_phase + i_angle_step;
        end
        if (w_adv) begin
            // stage 1: angle
            r1_sin  <= w_sin;
            r1_cos  <= w_cos;
            r1_idx  <= r_job.base_index + 16'(r_seg);
            r1_last <= w_last_seg;
            // stage 2: cos*P and sin*Q
            r2_cpx  <= r1_cos * r_job.p_x;
            r2_cpz  <= r1_cos * r_job.p_z;
            r2_sqx  <= r1_sin * r_job.q_x;
            r2_sqy  <= r1_sin * r_job.q_y;
            r2_sqz  <= r1_sin * r_job.q_z;
            r2_idx  <= r1_idx;
            r2_last <= r1_last;
            // stage 3: unit circle point
            r3_wx   <= clamp_w(54'(r2_cpx) + 54'(r2_sqx));
            r3_wy   <= clamp_w(54'(r2_sqy));
            r3_wz   <= clamp_w(54'(r2_cpz) + 54'(r2_sqz));
            r3_idx  <= r2_idx;
            r3_last <= r2_last;
            // stage 4: radius times W, split in two partial products
            r4_plx  <= 48'(r_job.radius) * 48'(r3_wx[16:0]);
            r4_ply  <= 48'(r_job.radius) * 48'(r3_wy[16:0]);
            r4_plz  <= 48'(r_job.radius) * 48'(r3_wz[16:0]);
            r4_phx  <= $signed({1'b0, r_job.radius}) * $signed(r3_wx[WW-1:17]);
            r4_phy  <= $signed({1'b0, r_job.radius}) * $signed(r3_wy[WW-1:17]);
            r4_phz  <= $signed({1'b0, r_job.radius}) * $signed(r3_wz[WW-1:17]);
            r4_idx  <= r3_idx;
            r4_last <= r3_last;
            // output register: offset from center, saturate
            r_out_item.point_index <= r4_idx;
            r_out_item.point_x     <= coord(r4_phx, r4_plx, r_job.center_x);
            r_out_item.point_y     <= coord(r4_phy, r4_ply, r_job.center_y);
            r_out_item.point_z     <= coord(r4_phz, r4_plz, r_job.center_z);
            r_out_item.last_point  <= r4_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_pipe_empty && !r_busy) else $error("ring loaded over live points");
    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_seg < r_count)) else $error("segment counter past ring end");

endmodule

[rtl/ring_vertex_generator.sv]
// A ring item goes through a 32-step square root, a 17-step divide pair and a cross product,
//   then its points run through a 5-stage point pipe.
// Throughput: one point per cycle while a ring runs and the output is not stalled; the front
//   builds the next ring while points stream out, but a ring loads only once the pipe drains.
// Reset (synchronous, active low): queue and pipes empty, segment_count = 16,
//   angle_step = 4096; the sine table is constant logic and needs no fill.
module ring_vertex_generator
    import rvg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // ring items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_ring_in              i_in_item,
    // point items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_ring_out             o_out_item,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SEG_W-1:0]  r_segment_count;
    logic [STEP_W-1:0] r_angle_step;

    t_ring_job w_push_job, w_pop_job;
    logic      w_push, w_pop, w_full, w_empty;

    // Config is only to be written while idle, so the back end reads it live; the block itself does not enforce this.
    // Bit 16 of angle_step is dropped: the phase is 16 bits and wraps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_count <= SEG_COUNT_RESET;
            r_angle_step    <= ANGLE_STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEGMENT_COUNT: r_segment_count <= i_cfg_data[SEG_W-1:0];
                CFG_ANGLE_STEP:    r_angle_step    <= i_cfg_data[STEP_W-1:0];
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    // Front: one ring at a time through the sqrt/divide unit
    rvg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // Two-ring queue lets the front work on the next ring while points stream out
    rvg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: phase stepping and per-point vertex math, output register at the end
    rvg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_segment_count (r_segment_count),
        .i_angle_step    (r_angle_step),
        .i_empty         (w_empty),
        .i_job           (w_pop_job),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_item      (o_out_item)
    );

endmodule
